// File: rtl/ors_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ors_pkg
// Shared types, codes and helpers of the 1-Wire ROM search engine.
// ----------------------------------------------------------------------------
package ors_pkg;

  localparam int ROM_W        = 64;
  localparam int POS_W        = 7;
  localparam int FAM_W        = 4;
  localparam int SDISC_W      = 12;
  localparam int END_POS      = 65;
  localparam int FAMILY_LIMIT = 9;
  localparam int TARGET_POS   = 64;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    K_FIRST  = 3'd0,
    K_NEXT   = 3'd1,
    K_VERIFY = 3'd2,
    K_TARGET = 3'd3,
    K_SKIP   = 3'd4,
    K_PRES   = 3'd5,
    K_PAIR   = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    ACT_RESET = 2'd0,
    ACT_CMD   = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_DONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_PRESENCE = 2'd1,
    PH_PAIR     = 2'd2
  } phase_t;

  typedef struct packed {
    action_t            action;
    logic               direction_bit;
    logic               found;
    logic [ROM_W-1:0]   rom_number;
    logic               last;
  } res_t;

  // Dallas/Maxim CRC8, reflected polynomial 0x8C, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ 8'h8C;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/ors_out_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ors_out_fifo
// Small result queue: takes up to two results per cycle, gives one per beat.
// ----------------------------------------------------------------------------
module ors_out_fifo (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [1:0]               push_n,
  input  wire ors_pkg::res_t            push_a,
  input  wire ors_pkg::res_t            push_b,
  output logic [ors_pkg::FIFO_CW-1:0]   count,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output ors_pkg::res_t                 out_data
);
  import ors_pkg::*;

  res_t                mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_r, wr_nxt;
  logic [FIFO_AW-1:0]  rd_r, rd_nxt;
  logic [FIFO_CW-1:0]  cnt_r, cnt_nxt;
  logic                pop;
  logic [FIFO_AW-1:0]  wr_b;

  assign pop       = (cnt_r != '0) && out_ready;
  assign wr_b      = wr_r + FIFO_AW'(1);
  assign wr_nxt    = wr_r + FIFO_AW'(push_n);
  assign rd_nxt    = rd_r + FIFO_AW'(pop);
  assign cnt_nxt   = cnt_r + FIFO_CW'(push_n) - FIFO_CW'(pop);
  assign count     = cnt_r;
  assign out_valid = (cnt_r != '0);
  assign out_data  = mem[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_r] <= push_a;
    end
    if (push_n == 2'd2) begin
      mem[wr_b] <= push_b;
    end
  end

endmodule
`default_nettype wire

// File: rtl/onewire_rom_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// onewire_rom_search
// 1-Wire ROM search engine: turns bus events into the next bus action.
// ----------------------------------------------------------------------------
// Latency: a result passes the input register and then the result queue before it is on out_*.
// Throughput: one input beat per cycle while the result queue has room; the queue
//   drains one beat per cycle, and the final bit pair pushes two results at once.
// in_tready drops only when the four-entry result queue is near full.
// Reset (rst_n low, synchronous) clears the search state and empties the queue.
module onewire_rom_search (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // family[7:0], presence, id_bit, complement_bit
  input  wire logic [2:0]  in_tuser,   // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // direction_bit, found, rom_number[63:0]
  output logic [1:0]       out_tuser,  // action
  output logic             out_tlast   // last
);
  import ors_pkg::*;

  // input stage
  logic             in_vld_r;
  kind_t            kind_r;
  logic [7:0]       fam_r;
  logic             pres_r, idb_r, cmb_r;
  logic             fire;

  // search state
  logic [ROM_W-1:0]   rom_r, rom_nxt;
  logic [POS_W-1:0]   ld_r, ld_nxt;
  logic [FAM_W-1:0]   lfd_r, lfd_nxt;
  logic               ldf_r, ldf_nxt;
  logic [POS_W-1:0]   bp_r, bp_nxt;
  logic [POS_W-1:0]   lzp_r, lzp_nxt;
  logic [7:0]         crc_r, crc_nxt;
  phase_t             phase_r, phase_nxt;
  logic               ver_r, ver_nxt;
  logic [ROM_W-1:0]   srom_r, srom_nxt;
  logic [SDISC_W-1:0] sdisc_r, sdisc_nxt;

  logic [1:0]         push_n;
  res_t               res_a, res_b;
  logic [FIFO_CW-1:0] q_count;
  res_t               q_out;

  assign fire      = in_vld_r && (q_count <= FIFO_CW'(FIFO_DEPTH - 2));
  assign in_tready = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      kind_r <= kind_t'(in_tuser);
      fam_r  <= in_tdata[7:0];
      pres_r <= in_tdata[8];
      idb_r  <= in_tdata[9];
      cmb_r  <= in_tdata[10];
    end
  end

  always_comb begin
    logic             start, do_fin, fin_ok, two, dir, bit_cur, found;
    logic [5:0]       idx;
    logic [7:0]       rbyte;
    logic [ROM_W-1:0] rom_mid;

    rom_nxt   = rom_r;
    ld_nxt    = ld_r;
    lfd_nxt   = lfd_r;
    ldf_nxt   = ldf_r;
    bp_nxt    = bp_r;
    lzp_nxt   = lzp_r;
    crc_nxt   = crc_r;
    phase_nxt = phase_r;
    ver_nxt   = ver_r;
    srom_nxt  = srom_r;
    sdisc_nxt = sdisc_r;
    push_n    = 2'd0;
    start     = 1'b0;
    do_fin    = 1'b0;
    fin_ok    = 1'b0;
    two       = 1'b0;
    dir       = 1'b0;
    found     = 1'b0;
    idx       = bp_r[5:0] - 6'd1;
    bit_cur   = rom_r[idx];
    rbyte     = '0;
    res_a     = '{action: ACT_RESET, direction_bit: 1'b0, found: 1'b0,
                  rom_number: rom_r, last: 1'b1};
    res_b     = res_a;

    if (fire && !((kind_r inside {K_FIRST, K_NEXT, K_VERIFY, K_TARGET, K_SKIP})
                  && phase_r != PH_IDLE)) begin
      case (kind_r)
        K_FIRST: begin
          ld_nxt  = '0;
          lfd_nxt = '0;
          ldf_nxt = 1'b0;
          start   = 1'b1;
        end
        K_NEXT: begin
          start = 1'b1;
        end
        K_VERIFY: begin
          srom_nxt  = rom_r;
          sdisc_nxt = {ldf_r, lfd_r, ld_r};
          ld_nxt    = POS_W'(TARGET_POS);
          ldf_nxt   = 1'b0;
          ver_nxt   = 1'b1;
          start     = 1'b1;
        end
        K_TARGET: begin
          rom_nxt = {{(ROM_W-8){1'b0}}, fam_r};
          ld_nxt  = POS_W'(TARGET_POS);
          lfd_nxt = '0;
          ldf_nxt = 1'b0;
        end
        K_SKIP: begin
          ld_nxt  = {{(POS_W-FAM_W){1'b0}}, lfd_r};
          lfd_nxt = '0;
          if (lfd_r == '0) begin
            ldf_nxt = 1'b1;
          end
        end
        K_PRES: begin
          if (phase_r == PH_PRESENCE) begin
            push_n = 2'd1;
            if (!pres_r) begin
              ld_nxt  = '0;
              lfd_nxt = '0;
              ldf_nxt = 1'b0;
              do_fin  = 1'b1;
            end else begin
              phase_nxt    = PH_PAIR;
              res_a.action = ACT_CMD;
            end
          end
        end
        K_PAIR: begin
          if (phase_r == PH_PAIR) begin
            push_n = 2'd1;
            if (idb_r && cmb_r) begin
              do_fin = 1'b1;
            end else begin
              if (idb_r != cmb_r) begin
                dir = idb_r;
              end else begin
                dir = (bp_r < ld_r) ? bit_cur : (bp_r == ld_r);
                if (!dir) begin
                  lzp_nxt = bp_r;
                  if (bp_r < POS_W'(FAMILY_LIMIT)) begin
                    lfd_nxt = bp_r[FAM_W-1:0];
                  end
                end
              end
              rom_nxt[idx] = dir;
              // a byte completes every eighth bit: fold it into the CRC
              if (idx[2:0] == 3'd7) begin
                rbyte   = rom_nxt[{idx[5:3], 3'b000} +: 8];
                crc_nxt = crc8_byte(crc_r, rbyte);
              end
              bp_nxt              = bp_r + POS_W'(1);
              res_a.action        = ACT_WRITE;
              res_a.direction_bit = dir;
              if (bp_nxt >= POS_W'(END_POS)) begin
                push_n     = 2'd2;
                two        = 1'b1;
                do_fin     = 1'b1;
                fin_ok     = (crc_nxt == 8'd0);
                res_a.last = 1'b0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (start) begin
      bp_nxt  = POS_W'(1);
      lzp_nxt = '0;
      crc_nxt = '0;
      push_n  = 2'd1;
      if (ldf_nxt) begin
        do_fin = 1'b1;
      end else begin
        phase_nxt = PH_PRESENCE;
      end
    end

    rom_mid = rom_nxt;

    if (do_fin) begin
      if (fin_ok) begin
        ld_nxt = lzp_nxt;
        if (lzp_nxt == '0) begin
          ldf_nxt = 1'b1;
        end
      end
      if (!fin_ok || rom_nxt[7:0] == 8'd0) begin
        ld_nxt  = '0;
        lfd_nxt = '0;
        ldf_nxt = 1'b0;
        fin_ok  = 1'b0;
      end
      found = fin_ok;
      // verify: compare, then put the saved search state back
      if (ver_nxt) begin
        found   = fin_ok && (rom_nxt == srom_nxt);
        rom_nxt = srom_nxt;
        ld_nxt  = sdisc_nxt[POS_W-1:0];
        lfd_nxt = sdisc_nxt[POS_W +: FAM_W];
        ldf_nxt = sdisc_nxt[SDISC_W-1];
        ver_nxt = 1'b0;
      end
      phase_nxt = PH_IDLE;
    end

    res_a.rom_number = two ? rom_mid : rom_nxt;
    res_b = '{action: ACT_DONE, direction_bit: 1'b0, found: found,
              rom_number: rom_nxt, last: 1'b1};
    if (do_fin && !two) begin
      res_a = res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_r   <= '0;
      ld_r    <= '0;
      lfd_r   <= '0;
      ldf_r   <= 1'b0;
      bp_r    <= POS_W'(1);
      lzp_r   <= '0;
      crc_r   <= '0;
      phase_r <= PH_IDLE;
      ver_r   <= 1'b0;
      srom_r  <= '0;
      sdisc_r <= '0;
    end else begin
      rom_r   <= rom_nxt;
      ld_r    <= ld_nxt;
      lfd_r   <= lfd_nxt;
      ldf_r   <= ldf_nxt;
      bp_r    <= bp_nxt;
      lzp_r   <= lzp_nxt;
      crc_r   <= crc_nxt;
      phase_r <= phase_nxt;
      ver_r   <= ver_nxt;
      srom_r  <= srom_nxt;
      sdisc_r <= sdisc_nxt;
    end
  end

  ors_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push_a    (res_a),
    .push_b    (res_b),
    .count     (q_count),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (q_out)
  );

  assign out_tdata = {6'd0, q_out.rom_number, q_out.found, q_out.direction_bit};
  assign out_tuser = q_out.action;
  assign out_tlast = q_out.last;

  a_verify_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ver_r |-> phase_r != PH_IDLE)
    else $error("verify flag set while idle");

  a_pair_pos: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAIR |-> (bp_r >= POS_W'(1) && bp_r <= POS_W'(TARGET_POS)))
    else $error("bit position out of range during pair phase");

  a_not_last_is_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> out_tuser == ACT_WRITE)
    else $error("non-final result beat is not a write");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue overflow");

endmodule
`default_nettype wire
